/* sv/dhs_pkg.sv */
// shared types and constants for the distance hash signature core
// no dependencies; used by every module of the block

package dhs_pkg;

   localparam int SUM_W = 48;

   // action codes
   localparam logic [1:0] ACT_PAIR   = 2'd0;
   localparam logic [1:0] ACT_MEDIAN = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_VECTOR_LENGTH  = 2'd0;
   localparam logic [1:0] REG_BITS_PER_TABLE = 2'd1;
   localparam logic [1:0] REG_TABLE_COUNT    = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         pivot_index;
      logic [6:0]         element_index;
      logic signed [15:0] first_value;
      logic signed [15:0] second_value;
      logic signed [31:0] median_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  table_index;
      logic [31:0] hash_word;
      logic        last_in_run;
   } rsp_type;

   // one pivot's sums and median, handed down the unload chain
   typedef struct packed {
      logic [SUM_W-1:0] proj;
      logic [SUM_W-1:0] len;
      logic [31:0]      med;
   } chain_type;

   // broadcast control from the top level to every cell
   typedef struct packed {
      logic               load_pair;
      logic               load_median;
      logic               query;
      logic               first;
      logic               capture;
      logic               shift;
      logic [7:0]         pivot;
      logic [6:0]         elem;
      logic signed [15:0] x;
      logic signed [15:0] x2;
      logic [31:0]        med;
   } cell_ctl_type;

endpackage

/* sv/dhs_cell.sv */
// one pivot cell: point memory, median, running sums and an unload stage
// depends on dhs_pkg

module dhs_cell
   import dhs_pkg::*;
#(
   parameter int MAX_DIM = 128,
   parameter int IDX     = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  chain_type    next_item,
   output chain_type    item
);

   localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [31:0] mem [0:MAX_DIM-1];
   logic [AW-1:0] addr;
   logic hit;

   logic [31:0] rd_ff;
   logic signed [15:0] x_ff;
   logic v1_ff, f1_ff, v2_ff, f2_ff, v3_ff, f3_ff;
   logic signed [16:0] dl_ff, dx_ff;
   logic signed [33:0] pp_ff, ll_ff;
   logic [SUM_W-1:0] proj_ff, proj_in, len_ff, len_in;
   logic [31:0] med_ff;
   chain_type sh_ff;

   logic signed [15:0] x1, x2;

   assign addr = AW'(ctl.elem);
   assign hit  = (int'(ctl.pivot) == IDX);
   assign x1   = rd_ff[31:16];
   assign x2   = rd_ff[15:0];

   always_ff @(posedge clock) begin
      if (ctl.load_pair && hit) begin
         mem[addr] <= {ctl.x, ctl.x2};
      end
      if (ctl.query) begin
         rd_ff <= mem[addr];
      end
   end

   always_comb begin
      proj_in = (f3_ff ? '0 : proj_ff) + SUM_W'(pp_ff);
      len_in  = (f3_ff ? '0 : len_ff) + SUM_W'(ll_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         proj_ff <= '0;
         len_ff  <= '0;
      end else begin
         v1_ff <= ctl.query;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (v3_ff) begin
            proj_ff <= proj_in;
            len_ff  <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.query) begin
         x_ff  <= ctl.x;
         f1_ff <= ctl.first;
      end
      dl_ff <= {x2[15], x2} - {x1[15], x1};
      dx_ff <= {x_ff[15], x_ff} - {x1[15], x1};
      f2_ff <= f1_ff;
      pp_ff <= dx_ff * dl_ff;
      ll_ff <= dl_ff * dl_ff;
      f3_ff <= f2_ff;
      if (ctl.load_median && hit) begin
         med_ff <= ctl.med;
      end
      // unload chain: capture own values, then pass toward cell zero
      if (ctl.capture) begin
         sh_ff <= '{proj: proj_ff, len: len_ff, med: med_ff};
      end else if (ctl.shift) begin
         sh_ff <= next_item;
      end
   end

   assign item = sh_ff;

endmodule

/* sv/dhs_judge.sv */
// exact projection-vs-median test for one pivot, the two compared products built 16 bits a step
// depends on dhs_pkg

module dhs_judge
   import dhs_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  chain_type item,
   output logic      done,
   output logic      bit_out
);

   typedef enum logic [3:0] {
      J_IDLE = 4'b0001,
      J_SQ   = 4'b0010,
      J_MUL  = 4'b0100,
      J_CMP  = 4'b1000
   } jstate_type;

   jstate_type state_ff, state_in;
   logic [1:0] k_ff, k_in;
   logic done_ff, done_in;
   logic bit_ff, bit_in;
   logic pneg_ff, mneg_ff, lzero_ff, mzero_ff;
   logic [SUM_W-1:0] pmag_ff, len_ff;
   logic [31:0] mmag_ff;
   logic [63:0] mm_ff;
   logic [95:0] pacc_ff, pacc_in;
   logic [111:0] racc_ff, racc_in;

   logic [15:0] pdig, sdig;
   logic [63:0] pprod;
   logic [79:0] rprod;
   logic lt, gt;

   always_comb begin
      pdig    = pmag_ff[{k_ff, 4'b0000} +: 16];
      sdig    = len_ff[{k_ff, 4'b0000} +: 16];
      pprod   = pmag_ff * pdig;
      rprod   = mm_ff * sdig;
      pacc_in = pacc_ff + (96'(pprod) << {k_ff, 4'b0000});
      racc_in = racc_ff + (112'(rprod) << {k_ff, 4'b0000});
      lt      = {16'b0, pacc_ff} < racc_ff;
      gt      = {16'b0, pacc_ff} > racc_ff;
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      done_in  = 1'b0;
      bit_in   = bit_ff;
      case (state_ff)
         J_IDLE: begin
            if (start) state_in = J_SQ;
         end
         J_SQ: begin
            k_in     = 2'd0;
            state_in = J_MUL;
         end
         J_MUL: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd2) state_in = J_CMP;
         end
         J_CMP: begin
            done_in = 1'b1;
            if (lzero_ff) bit_in = 1'b0;
            else if (mzero_ff) bit_in = pneg_ff;
            else if (!mneg_ff) bit_in = pneg_ff | lt;
            else bit_in = pneg_ff & gt;
            state_in = J_IDLE;
         end
         default: state_in = J_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= J_IDLE;
         k_ff     <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      if (state_ff == J_IDLE && start) begin
         pneg_ff  <= item.proj[SUM_W-1];
         pmag_ff  <= item.proj[SUM_W-1] ? (~item.proj + SUM_W'(1)) : item.proj;
         mneg_ff  <= item.med[31];
         mmag_ff  <= item.med[31] ? (~item.med + 32'd1) : item.med;
         len_ff   <= item.len;
         lzero_ff <= (item.len == '0);
         mzero_ff <= (item.med == '0);
      end
      if (state_ff == J_SQ) begin
         mm_ff   <= mmag_ff * mmag_ff;
         pacc_ff <= '0;
         racc_ff <= '0;
      end else if (state_ff == J_MUL) begin
         pacc_ff <= pacc_in;
         racc_ff <= racc_in;
      end
   end

   assign done    = done_ff;
   assign bit_out = bit_ff;

endmodule

/* sv/distance_hash_signature_core.sv */
// top level: register port, cell row, unload chain, judge and word output
// depends on dhs_pkg, dhs_cell, dhs_judge
//
//  channel  direction  handshake          word
//  req_     in         req_valid/stall    req_type (load pair, load median, query element)
//  rsp_     out        rsp_valid/stall    rsp_type (one hash word per table)
//  csr      in/out     psel/penable       32-bit registers at 0, 4, 8
//
// loads and query elements are taken one per cycle; each cell runs a 4-stage
// read/difference/multiply/accumulate pipe. after the last element the input
// stalls while the sums settle, then each hash bit is worked out in the shared
// judge (one 16-bit multiply step per cycle). rsp_stall holds the next word back.
// reset clears control and sums; point and median stores hold nothing
// meaningful until written.

module distance_hash_signature_core
   import dhs_pkg::*;
#(
   parameter int MAX_DIM    = 128,
   parameter int MAX_TABLES = 8,
   parameter int MAX_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NUM_PIVOTS = MAX_TABLES * MAX_BITS;
   localparam int LW  = $clog2(MAX_DIM + 1);
   localparam int TCW = $clog2(MAX_TABLES + 1);
   localparam int BW  = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
   localparam int TW  = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;

   typedef enum logic [4:0] {
      ST_RUN   = 5'b00001,
      ST_FLUSH = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   // configuration registers
   logic [7:0] vlen_ff;
   logic [5:0] bpt_ff;
   logic [3:0] tcnt_ff;
   logic [LW-1:0] len_c;
   logic [5:0] bits_c;
   logic [TCW-1:0] tabs_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= 8'd128;
         bpt_ff  <= 6'd16;
         tcnt_ff <= 4'd4;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_VECTOR_LENGTH:  vlen_ff <= pwdata[7:0];
            REG_BITS_PER_TABLE: bpt_ff  <= pwdata[5:0];
            REG_TABLE_COUNT:    tcnt_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_VECTOR_LENGTH:  prdata = {24'b0, vlen_ff};
         REG_BITS_PER_TABLE: prdata = {26'b0, bpt_ff};
         REG_TABLE_COUNT:    prdata = {28'b0, tcnt_ff};
         default:            prdata = 32'b0;
      endcase
   end

   assign pready = 1'b1;

   always_comb begin
      if (vlen_ff == 8'd0) len_c = LW'(1);
      else if (int'(vlen_ff) > MAX_DIM) len_c = LW'(MAX_DIM);
      else len_c = LW'(vlen_ff);
      if (bpt_ff == 6'd0) bits_c = 6'd1;
      else if (int'(bpt_ff) > MAX_BITS) bits_c = 6'(MAX_BITS);
      else bits_c = bpt_ff;
      if (tcnt_ff == 4'd0) tabs_c = TCW'(1);
      else if (int'(tcnt_ff) > MAX_TABLES) tabs_c = TCW'(MAX_TABLES);
      else tabs_c = TCW'(tcnt_ff);
   end

   // sequencing
   state_type state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [TW-1:0] tab_ff, tab_in;
   logic [31:0] hash_ff, hash_in;
   logic start_ff, start_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic accept, in_range, piv_ok, last_q;
   logic jd_done, jd_bit;
   logic [31:0] hash_new;
   logic out_free;
   cell_ctl_type ctl;
   chain_type head;

   assign req_stall = (state_ff != ST_RUN);
   assign accept    = req_valid && !req_stall;
   assign in_range  = int'(req_data.element_index) < int'(len_c);
   assign piv_ok    = int'(req_data.pivot_index) < NUM_PIVOTS;
   assign hash_new  = {hash_ff[30:0], jd_bit};
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ctl.load_pair   = accept && in_range && piv_ok && (req_data.action == ACT_PAIR);
      ctl.load_median = accept && in_range && piv_ok && (req_data.action == ACT_MEDIAN);
      ctl.query       = accept && in_range && (req_data.action == ACT_QUERY);
      ctl.first       = (req_data.element_index == 7'd0);
      ctl.capture     = (state_ff == ST_LOAD);
      ctl.shift       = jd_done;
      ctl.pivot       = req_data.pivot_index;
      ctl.elem        = req_data.element_index;
      ctl.x           = req_data.first_value;
      ctl.x2          = req_data.second_value;
      ctl.med         = req_data.median_value;
   end

   assign last_q = ctl.query && (int'(req_data.element_index) == int'(len_c) - 1);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bit_in       = bit_ff;
      tab_in       = tab_ff;
      hash_in      = hash_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_RUN: begin
            if (last_q) begin
               cnt_in   = 2'd0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // wait here while the last element's sums settle in the cells
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            bit_in   = '0;
            tab_in   = '0;
            hash_in  = 32'b0;
            start_in = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (jd_done) begin
               if (int'(bit_ff) == int'(bits_c) - 1) begin
                  hash_in  = hash_new << (6'd32 - bits_c);
                  state_in = ST_EMIT;
               end else begin
                  hash_in  = hash_new;
                  bit_in   = bit_ff + BW'(1);
                  start_in = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.table_index = 3'(tab_ff);
               rsp_in.hash_word   = hash_ff;
               rsp_in.last_in_run = (int'(tab_ff) == int'(tabs_c) - 1);
               if (int'(tab_ff) == int'(tabs_c) - 1) begin
                  state_in = ST_RUN;
               end else begin
                  tab_in   = tab_ff + TW'(1);
                  bit_in   = '0;
                  hash_in  = 32'b0;
                  start_in = 1'b1;
                  state_in = ST_EVAL;
               end
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         cnt_ff       <= 2'd0;
         bit_ff       <= '0;
         tab_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bit_ff       <= bit_in;
         tab_ff       <= tab_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // row of pivot cells, unloaded toward cell zero
   chain_type chain_w [0:NUM_PIVOTS-1];

   for (genvar i = 0; i < NUM_PIVOTS; i++) begin : g_cell
      chain_type nxt;
      if (i == NUM_PIVOTS - 1) begin : g_end
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = chain_w[i+1];
      end
      dhs_cell #(
         .MAX_DIM (MAX_DIM),
         .IDX     (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .next_item (nxt),
         .item      (chain_w[i])
      );
   end

   assign head = chain_w[0];

   dhs_judge u_judge (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .item    (head),
      .done    (jd_done),
      .bit_out (jd_bit)
   );

   a_done_in_eval: assert property (@(posedge clock) disable iff (reset)
      jd_done |-> state_ff == ST_EVAL)
      else $error("judge result outside evaluation");

   a_word_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result word not from emit state");

   a_bit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> int'(bit_ff) < int'(bits_c))
      else $error("hash bit counter past table width");

endmodule
